>>> design/mi3_pkg.sv
// Shared widths, stage counts and cofactor index table for the 3x3 inverse.
`default_nettype none
package mi3_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ENT_W         = 32;
	localparam int N_ENT         = 9;
	localparam int N_LANE        = 9;
	localparam int PROD_W        = 2 * ENT_W;
	localparam int COF_W         = PROD_W + 1;
	localparam int CMAG_W        = PROD_W;
	localparam int PART_W        = COF_W;
	localparam int TERM_W        = PART_W + ENT_W;
	localparam int DET_W         = TERM_W + 2;
	localparam int DW            = DET_W - 1;
	localparam int QW            = ENT_W + 1;
	localparam int DETMIN_W      = 31;
	localparam int TOP_STG       = 5;
	localparam int DIV_STG       = QW + 1;
	localparam int IDX_W         = 4;

	// Operand positions a, b, c, d of cofactor a*b - c*d, row-major entry index.
	localparam logic [IDX_W-1:0] COF_IDX [N_LANE][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd6, 4'd1, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd3, 4'd1}
	};

	typedef struct packed {
		logic              sing;
		logic [N_LANE-1:0] neg;
	} lane_ctl_t;

endpackage
`default_nettype wire

>>> design/mi3_div.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
`default_nettype none
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  wire                                                     clk,
	input  wire  [mi3_pkg::DIV_STG-1:0]                             ld,
	input  wire  [mi3_pkg::N_LANE-1:0][mi3_pkg::CMAG_W+2*FRAC_BITS-1:0] n_in,
	input  wire  [mi3_pkg::DW-1:0]                                  d_in,
	input  mi3_pkg::lane_ctl_t                                      ctl_in,
	output logic [mi3_pkg::N_LANE-1:0][mi3_pkg::QW-1:0]             q_out,
	output logic [mi3_pkg::N_LANE-1:0]                              ovf_out,
	output mi3_pkg::lane_ctl_t                                      ctl_out
);
	import mi3_pkg::*;

	localparam int NW = CMAG_W + 2 * FRAC_BITS;
	localparam int W  = DW + QW + 1;

	logic [N_LANE-1:0][NW-1:0] rem_s [DIV_STG];
	logic [N_LANE-1:0][QW-1:0] q_s   [DIV_STG];
	logic [N_LANE-1:0]         ovf_s [DIV_STG];
	logic [DW-1:0]             d_s   [DIV_STG];
	lane_ctl_t                 ctl_s [DIV_STG];

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < N_LANE; i++) begin
				rem_s[0][i] <= n_in[i];
				q_s[0][i]   <= '0;
				ovf_s[0][i] <= W'(n_in[i]) >= (W'(d_in) << QW);
			end
			d_s[0]   <= d_in;
			ctl_s[0] <= ctl_in;
		end
	end

	for (genvar s = 1; s < DIV_STG; s++) begin : g_stg
		localparam int B = QW - s;
		logic [W-1:0] dsh;
		assign dsh = W'(d_s[s-1]) << B;
		always_ff @(posedge clk) begin
			if (ld[s]) begin
				for (int i = 0; i < N_LANE; i++) begin
					ovf_s[s][i] <= ovf_s[s-1][i];
					if (!ovf_s[s-1][i] && (W'(rem_s[s-1][i]) >= dsh)) begin
						rem_s[s][i] <= rem_s[s-1][i] - dsh[NW-1:0];
						q_s[s][i]   <= q_s[s-1][i] | (QW'(1) << B);
					end else begin
						rem_s[s][i] <= rem_s[s-1][i];
						q_s[s][i]   <= q_s[s-1][i];
					end
				end
				d_s[s]   <= d_s[s-1];
				ctl_s[s] <= ctl_s[s-1];
			end
		end
	end

	assign q_out   = q_s[DIV_STG-1];
	assign ovf_out = ovf_s[DIV_STG-1];
	assign ctl_out = ctl_s[DIV_STG-1];

endmodule
`default_nettype wire

>>> design/matrix_inverse_3x3_top.sv
// Throughput: one matrix per cycle while m_tready is high; the divider has 34 stages.
// Every stage holds a valid bit and advances only when the next is free, so bubbles collapse.
// Reset: arst_n clears all valid bits and sets det_min to 1; data registers are not reset.
// Stages: products, cofactors, det partial products, det terms, det and threshold,
// divider (overflow check plus 33 quotient bits), saturation and output register.
`default_nettype none
module matrix_inverse_3x3_top #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2, in_r2c0, in_r2c1, in_r2c2
	input  wire  [mi3_pkg::N_ENT*mi3_pkg::ENT_W-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2, out_r2c0, out_r2c1, out_r2c2
	output logic [mi3_pkg::N_ENT*mi3_pkg::ENT_W-1:0] m_tdata,
	// singular
	output logic [0:0]                           m_tuser,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [mi3_pkg::DETMIN_W-1:0]         cfg_data
);
	import mi3_pkg::*;

	localparam int NW   = CMAG_W + 2 * FRAC_BITS;
	localparam int NSTG = TOP_STG + DIV_STG + 1;

	logic [DETMIN_W-1:0] det_min_q;
	logic [NSTG-1:0]     vld_q;
	logic [NSTG:0]       ld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= DETMIN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			det_min_q <= cfg_data;
		end
	end

	always_comb begin
		ld[NSTG] = m_tready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign s_tready = ld[0];
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	logic signed [ENT_W-1:0] ent [N_ENT];
	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			ent[i] = $signed(s_tdata[i*ENT_W +: ENT_W]);
		end
	end

	logic signed [PROD_W-1:0] pa_s1 [N_LANE];
	logic signed [PROD_W-1:0] pb_s1 [N_LANE];
	logic signed [ENT_W-1:0]  r0_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [N_LANE];
	logic signed [ENT_W-1:0]  r0_s2 [3];
	logic signed [COF_W-1:0]  cof_s3 [N_LANE];
	logic signed [PART_W-1:0] pl_s3 [3];
	logic signed [PART_W-1:0] ph_s3 [3];
	logic signed [COF_W-1:0]  cof_s4 [N_LANE];
	logic signed [TERM_W-1:0] term_s4 [3];

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int j = 0; j < N_LANE; j++) begin
				pa_s1[j] <= ent[COF_IDX[j][0]] * ent[COF_IDX[j][1]];
				pb_s1[j] <= ent[COF_IDX[j][2]] * ent[COF_IDX[j][3]];
			end
			for (int k = 0; k < 3; k++) begin
				r0_s1[k] <= ent[k];
			end
		end
		if (ld[1]) begin
			for (int j = 0; j < N_LANE; j++) begin
				cof_s2[j] <= $signed({pa_s1[j][PROD_W-1], pa_s1[j]})
					- $signed({pb_s1[j][PROD_W-1], pb_s1[j]});
			end
			r0_s2 <= r0_s1;
		end
		if (ld[2]) begin
			for (int k = 0; k < 3; k++) begin
				pl_s3[k] <= r0_s2[k] * $signed({1'b0, cof_s2[3*k][ENT_W-1:0]});
				ph_s3[k] <= r0_s2[k] * $signed(cof_s2[3*k][COF_W-1:ENT_W]);
			end
			cof_s3 <= cof_s2;
		end
		if (ld[3]) begin
			for (int k = 0; k < 3; k++) begin
				term_s4[k] <= $signed({ph_s3[k], {ENT_W{1'b0}}})
					+ $signed({{ENT_W{pl_s3[k][PART_W-1]}}, pl_s3[k]});
			end
			cof_s4 <= cof_s3;
		end
	end

	logic signed [DET_W-1:0] det;
	logic [DET_W-1:0]        det_neg;
	logic [DW-1:0]           dabs;
	logic [DW-1:0]           thr;
	logic                    sing;

	always_comb begin
		det = $signed({{2{term_s4[0][TERM_W-1]}}, term_s4[0]})
			+ $signed({{2{term_s4[1][TERM_W-1]}}, term_s4[1]})
			+ $signed({{2{term_s4[2][TERM_W-1]}}, term_s4[2]});
		det_neg = -det;
		dabs = det[DET_W-1] ? det_neg[DW-1:0] : det[DW-1:0];
		thr  = DW'(det_min_q) << (2 * FRAC_BITS);
		sing = (dabs == '0) || (dabs < thr);
	end

	logic [N_LANE-1:0][NW-1:0] n_s5;
	logic [DW-1:0]             d_s5;
	lane_ctl_t                 ctl_s5;
	logic [COF_W-1:0]          cneg [N_LANE];

	always_comb begin
		for (int j = 0; j < N_LANE; j++) begin
			cneg[j] = -cof_s4[j];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			for (int j = 0; j < N_LANE; j++) begin
				n_s5[j] <= {(cof_s4[j][COF_W-1] ? cneg[j][CMAG_W-1:0]
					: cof_s4[j][CMAG_W-1:0]), {(2*FRAC_BITS){1'b0}}};
				ctl_s5.neg[j] <= cof_s4[j][COF_W-1] ^ det[DET_W-1];
			end
			d_s5 <= dabs;
			ctl_s5.sing <= sing;
		end
	end

	logic [N_LANE-1:0][QW-1:0] q_div;
	logic [N_LANE-1:0]         ovf_div;
	lane_ctl_t                 ctl_div;

	mi3_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.ld      (ld[TOP_STG +: DIV_STG]),
		.n_in    (n_s5),
		.d_in    (d_s5),
		.ctl_in  (ctl_s5),
		.q_out   (q_div),
		.ovf_out (ovf_div),
		.ctl_out (ctl_div)
	);

	localparam logic [ENT_W-1:0] POS_MAX = {1'b0, {(ENT_W-1){1'b1}}};
	localparam logic [ENT_W-1:0] NEG_MIN = {1'b1, {(ENT_W-1){1'b0}}};

	logic [ENT_W-1:0] res [N_LANE];
	logic [ENT_W-1:0] qlo_neg [N_LANE];

	always_comb begin
		for (int j = 0; j < N_LANE; j++) begin
			qlo_neg[j] = -q_div[j][ENT_W-1:0];
			if (ctl_div.sing) begin
				res[j] = '0;
			end else if (!ctl_div.neg[j]) begin
				res[j] = (ovf_div[j] || q_div[j][QW-1] || q_div[j][ENT_W-1])
					? POS_MAX : q_div[j][ENT_W-1:0];
			end else begin
				res[j] = (ovf_div[j] || (q_div[j] > {1'b0, NEG_MIN}))
					? NEG_MIN : qlo_neg[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NSTG-1]) begin
			for (int j = 0; j < N_LANE; j++) begin
				m_tdata[j*ENT_W +: ENT_W] <= res[j];
			end
			m_tuser[0] <= ctl_div.sing;
		end
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("singular beat carries nonzero entries");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage empty");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted beat not captured in first stage");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse over stream ports.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import mi3_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LIMIT = 600000;
	localparam int SETTLE = 60;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SMIN = 32'h8000_0000;

	typedef struct {
		logic [31:0] ent [9];
		logic        sing;
	} inverse_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [N_ENT*ENT_W-1:0] s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [N_ENT*ENT_W-1:0] m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [DETMIN_W-1:0]    cfg_data = '0;

	logic [30:0] det_min_cur = 31'd1;
	inverse_t    pending_inverses [$];
	int          errors = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          typed_on = 1'b0;
	inverse_t    typed_inv;

	matrix_inverse_3x3_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic inverse_t invert(logic [N_ENT*ENT_W-1:0] d, logic [30:0] dmin);
		inverse_t r;
		logic signed [127:0] m [9];
		logic signed [127:0] c [9];
		logic signed [127:0] det;
		logic [127:0] dabs, cabs, q;
		bit neg;
		for (int i = 0; i < 9; i++)
			m[i] = 128'(signed'(d[32*i +: 32]));
		c[0] = m[4] * m[8] - m[5] * m[7];
		c[1] = m[2] * m[7] - m[1] * m[8];
		c[2] = m[1] * m[5] - m[2] * m[4];
		c[3] = m[5] * m[6] - m[3] * m[8];
		c[4] = m[0] * m[8] - m[2] * m[6];
		c[5] = m[3] * m[2] - m[0] * m[5];
		c[6] = m[3] * m[7] - m[4] * m[6];
		c[7] = m[6] * m[1] - m[0] * m[7];
		c[8] = m[0] * m[4] - m[3] * m[1];
		det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
		dabs = det < 0 ? -det : det;
		if (dabs == 0 || dabs < ({97'd0, dmin} << (2 * FB))) begin
			foreach (r.ent[i]) r.ent[i] = '0;
			r.sing = 1'b1;
			return r;
		end
		for (int i = 0; i < 9; i++) begin
			neg = (c[i] < 0) != (det < 0);
			cabs = c[i] < 0 ? -c[i] : c[i];
			q = (cabs << (2 * FB)) / dabs;
			if (!neg)
				r.ent[i] = q > 128'h7FFF_FFFF ? SMAX : q[31:0];
			else
				r.ent[i] = q > 128'h8000_0000 ? SMIN : -q[31:0];
		end
		r.sing = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
		if (s_tvalid && s_tready)
			pending_inverses.push_back(typed_on ? typed_inv : invert(s_tdata, det_min_cur));
		if (cfg_valid && cfg_ready)
			det_min_cur <= cfg_data;
		if (m_tvalid && m_tready) begin
			if (pending_inverses.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				inverse_t e;
				e = pending_inverses.pop_front();
				for (int i = 0; i < 9; i++)
					if (m_tdata[32*i +: 32] !== e.ent[i]) begin
						$error("out_r%0dc%0d expected %h actual %h", i / 3, i % 3,
							e.ent[i], m_tdata[32*i +: 32]);
						errors++;
					end
				if (m_tuser[0] !== e.sing) begin
					$error("singular expected %b actual %b", e.sing, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

	task automatic send_matrix(logic [N_ENT*ENT_W-1:0] d);
		if (!calm)
			while ($urandom_range(99) < 33) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
		s_tdata = d;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain;
		while (pending_inverses.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_det_min(logic [30:0] v);
		drain();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [N_ENT*ENT_W-1:0] pack9(logic [31:0] a0, logic [31:0] a1,
		logic [31:0] a2, logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
		logic [31:0] a6, logic [31:0] a7, logic [31:0] a8);
		return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
	endfunction

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($urandom_range(32'h40000) - 32'h20000);
			2: return $urandom_range(1) ? SMAX : SMIN;
			3: return 32'($urandom_range(600) - 300);
			default: return 32'($urandom_range(32'h30000) - 32'h18000);
		endcase
	endfunction

	function automatic logic [N_ENT*ENT_W-1:0] rand_matrix();
		logic [N_ENT*ENT_W-1:0] d;
		for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_entry();
		case ($urandom_range(9))
			0: d[32*3 +: 96] = d[0 +: 96];
			1: for (int i = 0; i < 9; i++) d[32*i +: 32] = $urandom;
			2: for (int i = 0; i < 3; i++)
				d[32*(4*i) +: 32] = 32'($urandom_range(32'h80000) + ONE);
			default: ;
		endcase
		return d;
	endfunction

	logic [N_ENT*ENT_W-1:0] dir_mat [$];
	bit                     dir_typed [$];
	inverse_t               dir_exp [$];

	task automatic add_row(logic [N_ENT*ENT_W-1:0] d, bit typed, logic [31:0] diag, bit sing);
		inverse_t e;
		for (int i = 0; i < 9; i++) e.ent[i] = (i % 4 == 0) ? diag : '0;
		e.sing = sing;
		dir_mat.push_back(d);
		dir_typed.push_back(typed);
		dir_exp.push_back(e);
	endtask

	initial begin
		logic [30:0] phases [4];
		phases = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd1};

		add_row(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, ONE, 0);
		add_row('0, 1, '0, 1);
		add_row({9{SMIN}}, 1, '0, 1);
		add_row({9{SMAX}}, 1, '0, 1);
		add_row(pack9(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE), 1, 32'h8000, 0);
		add_row(pack9(SMAX, 0, 0, 0, SMAX, 0, 0, 0, SMAX), 0, 0, 0);
		add_row(pack9(SMIN, 0, 0, 0, SMIN, 0, 0, 0, SMIN), 0, 0, 0);
		add_row(pack9(SMIN, SMAX, 0, SMAX, SMIN, 0, 0, 0, SMAX), 0, 0, 0);
		add_row(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1, '0, 1);
		add_row(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, 256), 0, 0, 0);
		add_row(pack9(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 0, 0);
		add_row(pack9(0, ONE, 0, ONE, 0, 0, 0, 0, ONE), 0, 0, 0);
		add_row(pack9(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE,
			8 * ONE, 10 * ONE), 0, 0, 0);
		add_row(pack9(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE,
			8 * ONE, 9 * ONE), 1, '0, 1);
		add_row({32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
			32'hF0F0_F0F0, 32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 32'hFFFF_0000}, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < dir_mat.size(); r++) begin
			typed_on = dir_typed[r];
			typed_inv = dir_exp[r];
			send_matrix(dir_mat[r]);
		end
		typed_on = 1'b0;
		for (int r = 0; r < 6; r++) begin
			if (r == 0) write_det_min(31'd0);
			send_matrix(dir_mat[5 + r]);
		end
		send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
		send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));

		for (int p = 0; p < 5; p++) begin
			write_det_min(p < 4 ? phases[p] : 31'($urandom));
			for (int k = 0; k < 160; k++) begin
				calm = (p == 2 && k >= 40 && k < 120);
				send_matrix(rand_matrix());
			end
			calm = 1'b0;
		end

		drain();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
